/* rtl/length_prefixed_nal_to_start_code_defines.svh */
// Assertion macros, written against clk and rst_n of the enclosing scope.
`ifndef LENGTH_PREFIXED_NAL_TO_START_CODE_DEFINES_SVH
`define LENGTH_PREFIXED_NAL_TO_START_CODE_DEFINES_SVH

// same-cycle implication
`define LPNSC_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

// next-cycle implication
`define LPNSC_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

/* rtl/lpnsc_pkg.sv */
`default_nettype none

package lpnsc_pkg;

    localparam logic [2:0] LEN_SIZE_RESET = 3'd4;
    localparam logic [2:0] LEN_SIZE_MIN   = 3'd1;
    localparam logic [2:0] LEN_SIZE_MAX   = 3'd4;

    localparam int unsigned START_CODE_LEN = 4;
    localparam logic [7:0]  SC_ZERO        = 8'h00;
    localparam logic [7:0]  SC_ONE         = 8'h01;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       last_of_tag;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       end_of_tag;
        logic       tag_error;
    } out_item_t;

    typedef logic [2:0] cfg_word_t;

    // parser -> emitter
    typedef struct packed {
        logic      load;
        logic      start_code;
        out_item_t item;
    } burst_t;

endpackage

`default_nettype wire

/* rtl/lpnsc_stream_if.sv */
`default_nettype none

interface lpnsc_stream_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* rtl/lpnsc_parser.sv */
`default_nettype none

module lpnsc_parser (
    input  wire logic            clk,
    input  wire logic            rst_n,
    lpnsc_stream_if.sink         avcc,
    input  wire logic [2:0]      length_size,
    input  wire logic            emit_free,
    output lpnsc_pkg::burst_t    burst
);
    import lpnsc_pkg::*;

    typedef enum logic [1:0] {
        PH_PREFIX = 2'd0,
        PH_NAL    = 2'd1,
        PH_DROP   = 2'd2
    } phase_t;

    logic      item_vld_reg, item_vld_next;
    in_item_t  item_reg, item_next;
    phase_t    phase_reg, phase_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic [31:0] rem_reg, rem_next;

    logic        consume;
    phase_t      eff_phase;
    logic [2:0]  cnt_inc;
    logic [31:0] rem_sh;
    logic [31:0] rem_dec;
    burst_t      res;

    assign consume    = item_vld_reg && emit_free;
    assign avcc.ready = !item_vld_reg || consume;

    assign cnt_inc = cnt_reg + 3'd1;
    assign rem_sh  = {rem_reg[23:0], item_reg.in_byte};
    assign rem_dec = rem_reg - 32'd1;

    always_comb
    begin
        eff_phase = phase_reg;
        if (phase_reg == PH_PREFIX && cnt_reg == 3'd0 &&
            (length_size < LEN_SIZE_MIN || length_size > LEN_SIZE_MAX))
        begin
            eff_phase = PH_DROP;
        end

        phase_next = eff_phase;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        res        = '0;

        unique case (eff_phase)
            PH_PREFIX:
            begin
                rem_next = rem_sh;
                if (cnt_inc >= length_size)
                begin
                    cnt_next = 3'd0;
                    if (rem_sh == 32'd0)
                    begin
                        if (item_reg.last_of_tag)
                        begin
                            res.load            = 1'b1;
                            res.item.end_of_tag = 1'b1;
                        end
                    end
                    else if (item_reg.last_of_tag)
                    begin
                        res.load            = 1'b1;
                        res.item.end_of_tag = 1'b1;
                        res.item.tag_error  = 1'b1;
                    end
                    else
                    begin
                        res.load       = 1'b1;
                        res.start_code = 1'b1;
                        phase_next     = PH_NAL;
                    end
                end
                else
                begin
                    cnt_next = cnt_inc;
                    if (item_reg.last_of_tag)
                    begin
                        res.load            = 1'b1;
                        res.item.end_of_tag = 1'b1;
                        res.item.tag_error  = 1'b1;
                    end
                end
            end
            PH_NAL:
            begin
                rem_next            = rem_dec;
                res.load            = 1'b1;
                res.item.out_byte   = item_reg.in_byte;
                res.item.byte_valid = 1'b1;
                res.item.end_of_tag = item_reg.last_of_tag;
                res.item.tag_error  = item_reg.last_of_tag && (rem_dec != 32'd0);
                if (rem_dec == 32'd0)
                begin
                    phase_next = PH_PREFIX;
                end
            end
            default:
            begin
                // dropping until end of tag
                if (item_reg.last_of_tag)
                begin
                    res.load            = 1'b1;
                    res.item.end_of_tag = 1'b1;
                    res.item.tag_error  = 1'b1;
                end
            end
        endcase

        if (item_reg.last_of_tag)
        begin
            phase_next = PH_PREFIX;
            cnt_next   = 3'd0;
            rem_next   = 32'd0;
        end

        res.load = res.load && consume;
    end

    assign burst = res;

    always_comb
    begin
        item_vld_next = item_vld_reg;
        item_next     = item_reg;
        if (avcc.ready)
        begin
            item_vld_next = avcc.valid;
            item_next     = avcc.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_vld_reg <= 1'b0;
            phase_reg    <= PH_PREFIX;
            cnt_reg      <= 3'd0;
            rem_reg      <= 32'd0;
        end
        else
        begin
            item_vld_reg <= item_vld_next;
            if (consume)
            begin
                phase_reg <= phase_next;
                cnt_reg   <= cnt_next;
                rem_reg   <= rem_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

endmodule

`default_nettype wire

/* rtl/lpnsc_emitter.sv */
`default_nettype none

module lpnsc_emitter (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire lpnsc_pkg::burst_t  burst,
    output logic                    emit_free,
    lpnsc_stream_if.source          annexb
);
    import lpnsc_pkg::*;

    localparam logic [1:0] SC_LAST = 2'(START_CODE_LEN - 1);

    logic      vld_reg, vld_next;
    logic      sc_reg, sc_next;
    out_item_t item_reg, item_next;
    logic [1:0] idx_reg, idx_next;
    logic       done;

    assign done      = vld_reg && annexb.ready && (!sc_reg || idx_reg == SC_LAST);
    assign emit_free = !vld_reg || done;

    always_comb
    begin
        annexb.valid = vld_reg;
        if (sc_reg)
        begin
            annexb.data.out_byte   = (idx_reg == SC_LAST) ? SC_ONE : SC_ZERO;
            annexb.data.byte_valid = 1'b1;
            annexb.data.end_of_tag = 1'b0;
            annexb.data.tag_error  = 1'b0;
        end
        else
        begin
            annexb.data = item_reg;
        end
    end

    always_comb
    begin
        vld_next  = vld_reg;
        sc_next   = sc_reg;
        item_next = item_reg;
        idx_next  = idx_reg;
        if (emit_free)
        begin
            vld_next  = burst.load;
            sc_next   = burst.start_code;
            item_next = burst.item;
            idx_next  = 2'd0;
        end
        else if (annexb.ready)
        begin
            idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
            sc_reg  <= 1'b0;
            idx_reg <= 2'd0;
        end
        else
        begin
            vld_reg <= vld_next;
            sc_reg  <= sc_next;
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

endmodule

`default_nettype wire

/* rtl/length_prefixed_nal_to_start_code.sv */
`default_nettype none
// Channel  Dir  Payload                                          Notes
// avcc     in   in_byte, last_of_tag                             tag payload words
// annexb   out  out_byte, byte_valid, end_of_tag, tag_error      stream words
// cfg      in   length_size (3 bits)                             always ready
//
// One input word per cycle unless stalled; a completed nonzero prefix emits
// the 4-word start code, holding the input while the start-code counter runs.
// An input word passes through the input register, then the result register.
// rst_n is asynchronous; length_size resets to 4, parser state to prefix.
// Output stalls back up through the result register into the input register.

module length_prefixed_nal_to_start_code (
    input  wire logic      clk,
    input  wire logic      rst_n,
    lpnsc_stream_if.sink   avcc,
    lpnsc_stream_if.source annexb,
    lpnsc_stream_if.sink   cfg
);
    import lpnsc_pkg::*;

    logic [2:0] len_size_reg, len_size_next;
    logic       emit_free;
    burst_t     burst;

    assign cfg.ready     = 1'b1;
    assign len_size_next = (cfg.valid) ? cfg.data : len_size_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_size_reg <= LEN_SIZE_RESET;
        end
        else
        begin
            len_size_reg <= len_size_next;
        end
    end

    lpnsc_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .avcc        (avcc),
        .length_size (len_size_reg),
        .emit_free   (emit_free),
        .burst       (burst)
    );

    lpnsc_emitter u_emitter (
        .clk       (clk),
        .rst_n     (rst_n),
        .burst     (burst),
        .emit_free (emit_free),
        .annexb    (annexb)
    );

endmodule

`default_nettype wire

/* rtl/lpnsc_checker.sv */
`default_nettype none
`include "length_prefixed_nal_to_start_code_defines.svh"

module lpnsc_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       annexb_valid,
    input wire logic       annexb_ready,
    input wire logic [7:0] out_byte,
    input wire logic       byte_valid,
    input wire logic       end_of_tag,
    input wire logic       tag_error,
    input wire logic       cfg_valid,
    input wire logic       cfg_ready
);
    `LPNSC_ASSERT_NEXT(a_out_hold, annexb_valid && !annexb_ready, annexb_valid && $stable(out_byte) && $stable(byte_valid) && $stable(end_of_tag) && $stable(tag_error))
    `LPNSC_ASSERT_NOW(a_empty_zero, annexb_valid && !byte_valid, out_byte == 8'h00)
    `LPNSC_ASSERT_NOW(a_err_at_end, annexb_valid && tag_error, end_of_tag)
    `LPNSC_ASSERT_NOW(a_cfg_taken, cfg_valid, cfg_ready)
endmodule

bind length_prefixed_nal_to_start_code lpnsc_checker u_lpnsc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .annexb_valid (annexb.valid),
    .annexb_ready (annexb.ready),
    .out_byte     (annexb.data.out_byte),
    .byte_valid   (annexb.data.byte_valid),
    .end_of_tag   (annexb.data.end_of_tag),
    .tag_error    (annexb.data.tag_error),
    .cfg_valid    (cfg.valid),
    .cfg_ready    (cfg.ready)
);

`default_nettype wire
